FILE: design/gcd_pkg.sv
// Package for the great circle distance core: widths, CORDIC constants,
// the arctangent table, and the stage payload type shared by the CORDIC cell and the top level.
`default_nettype none
package gcd_pkg;
  localparam int CORDIC_STAGES = 24;
  localparam int STG_N = (CORDIC_STAGES < 62) ? CORDIC_STAGES : 62;
  localparam int IDX_W = 6;
  localparam int QW = 34;
  localparam int ZW = 33;
  localparam int RAD_W = 13;
  localparam int DIST_W = 22;
  localparam logic signed [QW-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [QW-1:0] Q30_ONE = 34'sd1073741824;
  localparam logic [35:0] HALF_UDEG_Q62 = 36'd40244552543;
  localparam logic signed [31:0] FULL_TURN_H = 32'sd720000000;
  localparam logic signed [31:0] HALF_TURN_H = 32'sd360000000;
  localparam logic signed [31:0] QUARTER_TURN_H = 32'sd180000000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic signed [QW-1:0] q_t;

  function automatic q_t atan_q30(input logic [IDX_W-1:0] i);
    q_t r;
    r = '0;
    case (i)
      6'd0: r = 34'sd843314857;
      6'd1: r = 34'sd497837829;
      6'd2: r = 34'sd263043837;
      6'd3: r = 34'sd133525159;
      6'd4: r = 34'sd67021687;
      6'd5: r = 34'sd33543516;
      6'd6: r = 34'sd16775851;
      6'd7: r = 34'sd8388437;
      6'd8: r = 34'sd4194283;
      6'd9: r = 34'sd2097149;
      6'd10: r = 34'sd1048576;
      default: begin
        if (i <= 6'd30) r = q_t'(34'sd1 <<< (6'd30 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: design/gcd_if.sv
// Valid/ready channel interface used for the point pair input and the
// distance output. Depends on nothing.
`default_nettype none
interface gcd_pair_if;
  logic valid;
  logic ready;
  logic signed [27:0] first_latitude;
  logic signed [28:0] first_longitude;
  logic signed [27:0] second_latitude;
  logic signed [28:0] second_longitude;
  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_dist_if;
  logic valid;
  logic ready;
  logic [21:0] arc_distance;
  modport source (output valid, arc_distance, input ready);
  modport sink (input valid, arc_distance, output ready);
endinterface
`default_nettype wire

FILE: design/gcd_rot_cell.sv
// One CORDIC stage cell, used for rotation (sine) and vectoring (arctangent).
// Depends on gcd_pkg.
`default_nettype none
module gcd_rot_cell
  import gcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic             vec_mode,
  input  wire q_t               x_in,
  input  wire q_t               y_in,
  input  wire q_t               z_in,
  output q_t                    x_r,
  output q_t                    y_r,
  output q_t                    z_r
);
  q_t xs, ys, at;
  logic pos;
  always_comb begin
    xs = x_in >>> idx;
    ys = y_in >>> idx;
    at = atan_q30(idx);
    pos = vec_mode ? (y_in < 0) : (z_in >= 0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= pos ? x_in - ys : x_in + ys;
      y_r <= pos ? y_in + xs : y_in - xs;
      z_r <= pos ? z_in - at : z_in + at;
    end
  end
endmodule
`default_nettype wire

FILE: design/gcd_sqrt_cell.sv
// One digit cell of the restoring square root chain (two bits per cell).
// Depends on gcd_pkg.
`default_nettype none
module gcd_sqrt_cell
  import gcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [5:0]  k,
  input  wire logic [61:0] n_in,
  input  wire logic [61:0] res_in,
  output logic [61:0]      n_r,
  output logic [61:0]      res_r
);
  logic [61:0] bitv, t;
  always_comb begin
    bitv = 62'd1 << {k, 1'b0};
    t = res_in + bitv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= t) begin
        n_r <= n_in - t;
        res_r <= (res_in >> 1) + bitv;
      end else begin
        n_r <= n_in;
        res_r <= res_in >> 1;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/great_circle_distance_core.sv
// Top level of the haversine great circle distance pipeline.
// Depends on gcd_pkg, gcd_if, gcd_rot_cell and gcd_sqrt_cell.
// One point pair enters per clock and one distance leaves per clock while the
// pipeline moves; the path runs through six angle reduction stages, the sine
// and vectoring CORDIC cell chains, three haversine stages, the 31-cell square
// root chain and three scaling stages.
// The pipeline moves while the output beat is taken or the last stage is empty.
`default_nettype none
module great_circle_distance_core
  import gcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [RAD_W-1:0] cfg_wdata,
  gcd_pair_if.sink              in_ch,
  gcd_dist_if.source            out_ch
);
  localparam int LAT = 6 + STG_N + 3 + 31 + STG_N + 3;

  logic [RAD_W-1:0] radius_r;
  logic [LAT-1:0] vld_r;
  logic en;

  assign en = out_ch.ready || !vld_r[LAT-1];
  assign in_ch.ready = en;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(3440);
      vld_r <= '0;
    end else begin
      if (cfg_we) radius_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Stage 1: angle differences in half-microdegrees.
  logic signed [31:0] h_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      h_r[0] <= 32'(in_ch.second_latitude) - 32'(in_ch.first_latitude);
      h_r[1] <= 32'(in_ch.second_longitude) - 32'(in_ch.first_longitude);
      h_r[2] <= QUARTER_TURN_H - (32'(in_ch.first_latitude) <<< 1);
      h_r[3] <= QUARTER_TURN_H - (32'(in_ch.second_latitude) <<< 1);
    end
  end

  // Stages 2-6: reduction modulo a full turn, fold into a quarter turn, and scaling into the CORDIC angle.
  logic signed [31:0] m_r [4];
  logic signed [31:0] f_r [4];
  logic [28:0] mag_r [4];
  logic neg_r [4];
  logic [64:0] prod_r [4];
  logic neg2_r [4];
  q_t z0_r [4];
  for (genvar c = 0; c < 4; c++) begin : g_red
    logic signed [31:0] r0, r1, f;
    always_comb begin
      r0 = h_r[c];
      if (r0 >= FULL_TURN_H) r0 = r0 - FULL_TURN_H;
      if (r0 >= FULL_TURN_H) r0 = r0 - FULL_TURN_H;
      if (r0 < 0) r0 = r0 + FULL_TURN_H;
      if (r0 < 0) r0 = r0 + FULL_TURN_H;
      r1 = m_r[c];
      if (r1 >= HALF_TURN_H) r1 = r1 - FULL_TURN_H;
      f = f_r[c];
      if (f > QUARTER_TURN_H) f = HALF_TURN_H - f;
      if (f < -QUARTER_TURN_H) f = -HALF_TURN_H - f;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[c] <= r0;
        f_r[c] <= r1;
        mag_r[c] <= f < 0 ? 29'(-f) : 29'(f);
        neg_r[c] <= f < 0;
        prod_r[c] <= 65'(mag_r[c]) * 65'(HALF_UDEG_Q62);
        neg2_r[c] <= neg_r[c];
        z0_r[c] <= neg2_r[c] ? -q_t'((prod_r[c] + 65'(33'h80000000)) >> 32)
                             :  q_t'((prod_r[c] + 65'(33'h80000000)) >> 32);
      end
    end
  end

  // Four sine CORDIC chains.
  q_t sx [4][STG_N+1];
  q_t sy [4][STG_N+1];
  q_t sz [4][STG_N+1];
  for (genvar c = 0; c < 4; c++) begin : g_sin
    assign sx[c][0] = INV_GAIN;
    assign sy[c][0] = '0;
    assign sz[c][0] = z0_r[c];
    for (genvar i = 0; i < STG_N; i++) begin : g_st
      gcd_rot_cell u_cell (
        .clk(clk), .en(en), .idx(IDX_W'(i)), .vec_mode(1'b0),
        .x_in(sx[c][i]), .y_in(sy[c][i]), .z_in(sz[c][i]),
        .x_r(sx[c][i+1]), .y_r(sy[c][i+1]), .z_r(sz[c][i+1])
      );
    end
  end

  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return q_t'(p >>> 30);
  endfunction

  // Haversine term: two product stages and a sum stage, then clamp.
  q_t p1_r, p2_r, p3_r, p4_r, ha_r;
  q_t a_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= mulq(sy[0][STG_N], sy[0][STG_N]);
      p2_r <= mulq(sy[1][STG_N], sy[1][STG_N]);
      p3_r <= mulq(sy[2][STG_N], sy[3][STG_N]);
      p4_r <= p1_r;
      ha_r <= mulq(p3_r, p2_r);
      a_r <= p4_r + ha_r;
    end
  end

  q_t ac;
  always_comb begin
    ac = a_r;
    if (ac < 0) ac = '0;
    if (ac > Q30_ONE) ac = Q30_ONE;
  end

  // Two square root chains of 31 digit cells.
  logic [61:0] sn [2][32];
  logic [61:0] sr [2][32];
  assign sn[0][0] = 62'(Q30_ONE - ac) << 30;
  assign sn[1][0] = 62'(ac) << 30;
  assign sr[0][0] = '0;
  assign sr[1][0] = '0;
  for (genvar c = 0; c < 2; c++) begin : g_sq
    for (genvar i = 0; i < 31; i++) begin : g_d
      gcd_sqrt_cell u_cell (
        .clk(clk), .en(en), .k(6'(30 - i)),
        .n_in(sn[c][i]), .res_in(sr[c][i]),
        .n_r(sn[c][i+1]), .res_r(sr[c][i+1])
      );
    end
  end

  // Vectoring CORDIC chain for the arctangent.
  q_t vx [STG_N+1];
  q_t vy [STG_N+1];
  q_t vz [STG_N+1];
  assign vx[0] = q_t'(sr[0][31]);
  assign vy[0] = q_t'(sr[1][31]);
  assign vz[0] = '0;
  for (genvar i = 0; i < STG_N; i++) begin : g_vec
    gcd_rot_cell u_cell (
      .clk(clk), .en(en), .idx(IDX_W'(i)), .vec_mode(1'b1),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_r(vx[i+1]), .y_r(vy[i+1]), .z_r(vz[i+1])
    );
  end

  // Scale by radius and 200, round, saturate.
  logic [ZW-1:0] zc_r;
  logic [ZW+RAD_W-1:0] zr_r;
  logic [DIST_W-1:0] dist_r;
  logic [ZW+RAD_W+8:0] dd;
  always_comb begin
    dd = ((ZW+RAD_W+9)'(zr_r) * (ZW+RAD_W+9)'(200) + (ZW+RAD_W+9)'(30'h20000000)) >> 30;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zc_r <= (vz[STG_N] < 0) ? '0 : ZW'(vz[STG_N]);
      zr_r <= (ZW+RAD_W)'(zc_r) * (ZW+RAD_W)'(radius_r);
      dist_r <= (dd > (ZW+RAD_W+9)'(DIST_MAX)) ? DIST_MAX : DIST_W'(dd);
    end
  end
  assign out_ch.arc_distance = dist_r;
endmodule
`default_nettype wire
